// ===== rtl/mlisc_pkg.sv =====
package mlisc_pkg;

    // fixed field widths
    localparam int PixW = 8;
    localparam int RegW = PixW + 1;   // region count 1..256

    typedef logic [PixW-1:0] pix_t;
    typedef logic [RegW-1:0] regions_t;

    // plane count after reset
    localparam pix_t PlaneCountReset = 8'd7;

    // one quotient bit per divider stage
    localparam int DivSteps = PixW;

    localparam pix_t ChanFull = 8'hFF;
    localparam pix_t ChanZero = 8'h00;

    // hue sectors of the hsv wheel
    localparam logic [2:0] SectRedYellow   = 3'd0;
    localparam logic [2:0] SectYellowGreen = 3'd1;
    localparam logic [2:0] SectGreenCyan   = 3'd2;
    localparam logic [2:0] SectCyanBlue    = 3'd3;
    localparam logic [2:0] SectBlueMagenta = 3'd4;

endpackage

// ===== rtl/multi_level_intensity_slice_color_unit.sv =====
// channel    | ports                                          | transfer when
// -----------+------------------------------------------------+---------------------
// config     | cfg_we, cfg_wdata[7:0]                         | cfg_we high
// pixel in   | s_valid, s_ready, s_gray_level[7:0]            | s_valid && s_ready
// color out  | m_valid, m_ready, m_red_out, m_green_out,      | m_valid && m_ready
//            | m_blue_out (8 bits each)                       |
//
// one pixel per clock while m_ready stays high; each pixel passes through
// thirteen register stages: index multiply, two sector subtract steps, ramp numerator,
// eight divider stages of one quotient bit each, rounding and color select in the output
// synchronous active-low reset clears all stage valid bits and loads plane count 7
// each stage holds only while it is full and the stage after it cannot take its data,
// so bubbles collapse and input transfers stall only once all thirteen stages are full
module multi_level_intensity_slice_color_unit (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_we,
    input  mlisc_pkg::pix_t   cfg_wdata,
    input  logic              s_valid,
    output logic              s_ready,
    input  mlisc_pkg::pix_t   s_gray_level,
    output logic              m_valid,
    input  logic              m_ready,
    output mlisc_pkg::pix_t   m_red_out,
    output mlisc_pkg::pix_t   m_green_out,
    output mlisc_pkg::pix_t   m_blue_out
);
    import mlisc_pkg::*;

    // stage map: 0 index, 1 minus 4R, 2 minus 2R, 3 ramp numerator,
    // 4..11 divider, 12 output
    localparam int StgDiv0 = 4;
    localparam int NStg    = StgDiv0 + DivSteps + 1;
    localparam int StgOut  = NStg - 1;

    // configuration register: the user must write it only while the pipeline is empty
    // (the block does not enforce this), so every stage may read it directly
    pix_t     plane_count_reg;
    regions_t regions;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            plane_count_reg <= PlaneCountReset;
        end else if (cfg_we) begin
            plane_count_reg <= cfg_wdata;
        end
    end

    assign regions = {1'b0, plane_count_reg} + regions_t'(1);

    // per-stage valid and load enable
    logic [NStg-1:0] valid_reg;
    logic [NStg-1:0] adv;

    genvar k;
    generate
        for (k = 0; k < NStg; k++) begin : g_adv
            if (k == NStg - 1) begin : g_last
                assign adv[k] = !valid_reg[k] || m_ready;
            end else begin : g_mid
                assign adv[k] = !valid_reg[k] || adv[k+1];
            end
        end
    endgenerate

    assign s_ready = adv[0];
    assign m_valid = valid_reg[StgOut];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            if (adv[0]) begin
                valid_reg[0] <= s_valid;
            end
            for (int i = 1; i < NStg; i++) begin
                if (adv[i]) begin
                    valid_reg[i] <= valid_reg[i-1];
                end
            end
        end
    end

    // stage 0: region index = floor(gray * R / 256)
    logic [16:0] prod;
    pix_t        idx_next;
    pix_t        idx_reg;
    regions_t    last_idx;

    always_comb begin
        prod     = {9'b0, s_gray_level} * {8'b0, regions};
        last_idx = regions - regions_t'(1);
        idx_next = prod[15:8];
        // gray never exceeds 255, so this limit stays inactive
        if ({1'b0, prod[15:8]} > last_idx) begin
            idx_next = last_idx[PixW-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv[0]) begin
            idx_reg <= idx_next;
        end
    end

    // stage 1: n = 6 * idx, take out 4R
    logic [10:0] six_idx;
    logic [10:0] four_r;
    logic        q2_next;
    logic [10:0] rem4_next;
    logic        q2_reg;
    logic [10:0] rem4_reg;

    always_comb begin
        six_idx   = {1'b0, idx_reg, 2'b0} + {2'b0, idx_reg, 1'b0};
        four_r    = {regions, 2'b0};
        q2_next   = (six_idx >= four_r);
        rem4_next = q2_next ? (six_idx - four_r) : six_idx;
    end

    always_ff @(posedge aclk) begin
        if (adv[1]) begin
            q2_reg   <= q2_next;
            rem4_reg <= rem4_next;
        end
    end

    // stage 2: take out 2R, leaving t = n mod 2R
    logic [10:0] two_r;
    logic        q1_next;
    logic [10:0] t_wide;
    logic [1:0]  sect_hi_reg;
    logic [9:0]  t_reg;

    always_comb begin
        two_r   = {1'b0, regions, 1'b0};
        q1_next = (rem4_reg >= two_r);
        t_wide  = q1_next ? (rem4_reg - two_r) : rem4_reg;
    end

    always_ff @(posedge aclk) begin
        if (adv[2]) begin
            sect_hi_reg <= {q2_reg, q1_next};
            t_reg       <= t_wide[9:0];
        end
    end

    // stage 3: ramp numerator 255 * (R - |t - R|)
    logic        t_ge_r;
    logic [9:0]  t_dist;
    regions_t    ramp_m;
    logic [16:0] num_wide;
    logic [2:0]  sect3_reg;
    logic [15:0] num_reg;

    always_comb begin
        t_ge_r   = (t_reg >= {1'b0, regions});
        t_dist   = t_ge_r ? (t_reg - {1'b0, regions}) : ({1'b0, regions} - t_reg);
        ramp_m   = regions - t_dist[RegW-1:0];
        num_wide = {ramp_m, 8'b0} - {8'b0, ramp_m};
    end

    always_ff @(posedge aclk) begin
        if (adv[3]) begin
            sect3_reg <= {sect_hi_reg, t_ge_r};
            num_reg   <= num_wide[15:0];
        end
    end

    // stages 4..11: restoring divide num / R, msb of quotient first
    logic [15:0]     div_p_reg    [DivSteps];
    logic [PixW-1:0] div_q_reg    [DivSteps];
    logic [2:0]      div_sect_reg [DivSteps];

    generate
        for (k = 0; k < DivSteps; k++) begin : g_div
            logic [15:0]     p_in;
            logic [PixW-1:0] q_in;
            logic [2:0]      sect_in;
            logic [16:0]     dvs;
            logic            take;
            logic [16:0]     p_diff;
            logic [15:0]     p_next;
            logic [PixW-1:0] q_next;

            if (k == 0) begin : g_first
                assign p_in    = num_reg;
                assign q_in    = '0;
                assign sect_in = sect3_reg;
            end else begin : g_rest
                assign p_in    = div_p_reg[k-1];
                assign q_in    = div_q_reg[k-1];
                assign sect_in = div_sect_reg[k-1];
            end

            always_comb begin
                dvs    = {8'b0, regions} << (DivSteps - 1 - k);
                take   = ({1'b0, p_in} >= dvs);
                p_diff = {1'b0, p_in} - dvs;
                p_next = take ? p_diff[15:0] : p_in;
                q_next = q_in;
                q_next[DivSteps-1-k] = take;
            end

            always_ff @(posedge aclk) begin
                if (adv[StgDiv0 + k]) begin
                    div_p_reg[k]    <= p_next;
                    div_q_reg[k]    <= q_next;
                    div_sect_reg[k] <= sect_in;
                end
            end
        end
    endgenerate

    // output stage: round half to even, then pick channels by sector
    logic [PixW-1:0] quo;
    logic [9:0]      twice_rem;
    logic            round_up;
    regions_t        quo_rnd;
    pix_t            ramp;
    pix_t            red_next;
    pix_t            green_next;
    pix_t            blue_next;
    pix_t            red_reg;
    pix_t            green_reg;
    pix_t            blue_reg;

    always_comb begin
        quo       = div_q_reg[DivSteps-1];
        // remainder is below R, so nine bits hold it
        twice_rem = {div_p_reg[DivSteps-1][RegW-1:0], 1'b0};
        round_up  = (twice_rem > {1'b0, regions}) ||
                    ((twice_rem == {1'b0, regions}) && quo[0]);
        quo_rnd   = {1'b0, quo} + {{(RegW-1){1'b0}}, round_up};
        ramp      = quo_rnd[PixW] ? ChanFull : quo_rnd[PixW-1:0];

        red_next   = ChanZero;
        green_next = ChanZero;
        blue_next  = ChanZero;
        case (div_sect_reg[DivSteps-1])
            SectRedYellow: begin
                red_next   = ChanFull;
                green_next = ramp;
            end
            SectYellowGreen: begin
                red_next   = ramp;
                green_next = ChanFull;
            end
            SectGreenCyan: begin
                green_next = ChanFull;
                blue_next  = ramp;
            end
            SectCyanBlue: begin
                green_next = ramp;
                blue_next  = ChanFull;
            end
            SectBlueMagenta: begin
                red_next  = ramp;
                blue_next = ChanFull;
            end
            default: begin
                // magenta back toward red
                red_next  = ChanFull;
                blue_next = ramp;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (adv[StgOut]) begin
            red_reg   <= red_next;
            green_reg <= green_next;
            blue_reg  <= blue_next;
        end
    end

    assign m_red_out   = red_reg;
    assign m_green_out = green_reg;
    assign m_blue_out  = blue_reg;

endmodule
